// File: hdl/hds_pkg.sv
// Shared constants and register codes for the five-point heat stencil.
package hds_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_GRID    = 1024;

    localparam int GRID_W      = 11;
    localparam int RATIO_W     = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_RATIO = 1'd1;

    localparam int GRID_RESET  = 1024;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd13107;

    localparam int OUT_DEPTH   = 8;
endpackage

// File: hdl/hds_if.sv
// Handshake channel interfaces: grid input, result output, configuration writes.
interface hds_in_if #(
    parameter int VW = hds_pkg::VALUE_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

interface hds_out_if #(
    parameter int VW = hds_pkg::VALUE_WIDTH,
    parameter int CW = $clog2(hds_pkg::MAX_GRID)
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] new_temperature;
    logic [CW-1:0]        row_index;
    logic [CW-1:0]        col_index;
    logic                 frame_last;

    modport source (output valid, output new_temperature, output row_index,
                    output col_index, output frame_last, input ready);
    modport sink   (input valid, input new_temperature, input row_index,
                    input col_index, input frame_last, output ready);
endinterface

interface hds_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hds_pkg::CFG_IDX_W-1:0]       index;
    logic [hds_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/hds_update.sv
// Pipelined FTCS update: neighbor sum, lambda multiply, round and saturate.
module hds_update #(
    parameter int VW    = hds_pkg::VALUE_WIDTH,
    parameter int TAG_W = 21
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [TAG_W-1:0]                  i_tag,
    input  logic signed [VW-1:0]             i_up,
    input  logic signed [VW-1:0]             i_down,
    input  logic signed [VW-1:0]             i_left,
    input  logic signed [VW-1:0]             i_right,
    input  logic signed [VW-1:0]             i_center,
    input  logic [hds_pkg::RATIO_W-1:0]      i_lambda,
    output logic                              o_valid,
    output logic [TAG_W-1:0]                  o_tag,
    output logic signed [VW-1:0]             o_value
);
    import hds_pkg::*;

    localparam int SW = VW + 3;
    localparam int PW = SW + RATIO_W + 1;
    localparam int AW = VW + 4;
    localparam logic signed [AW-1:0] VMAX = {{5{1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [AW-1:0] VMIN = {{5{1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF = PW'(32768);

    logic                  r_a_valid, r_b_valid;
    logic [TAG_W-1:0]      r_a_tag, r_b_tag;
    logic signed [SW-1:0]  r_a_sum;
    logic signed [VW-1:0]  r_a_u, r_b_u;
    logic signed [PW-1:0]  r_b_prod;

    logic signed [SW-1:0]  n_sum;
    logic signed [PW-1:0]  rounded;
    logic signed [SW-1:0]  term;
    logic signed [AW-1:0]  total;

    always_comb begin
        n_sum = SW'(i_up) + SW'(i_down) + SW'(i_left) + SW'(i_right)
              - (SW'(i_center) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        r_a_tag  <= i_tag;
        r_a_sum  <= n_sum;
        r_a_u    <= i_center;
        r_b_tag  <= r_a_tag;
        r_b_u    <= r_a_u;
        r_b_prod <= PW'(r_a_sum) * PW'(signed'({1'b0, i_lambda}));
    end

    // round to nearest, ties up, then saturate
    always_comb begin
        rounded = r_b_prod + HALF;
        term    = SW'(rounded >>> 16);
        total   = AW'(r_b_u) + AW'(term);
        if (total > VMAX) begin
            o_value = VMAX[VW-1:0];
        end else if (total < VMIN) begin
            o_value = VMIN[VW-1:0];
        end else begin
            o_value = total[VW-1:0];
        end
    end

    assign o_valid = r_b_valid;
    assign o_tag   = r_b_tag;
endmodule

// File: hdl/hds_fifo.sv
// Small result queue that decouples the pipeline from the output receiver.
module hds_fifo #(
    parameter int W     = 53,
    parameter int DEPTH = hds_pkg::OUT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [W-1:0]  i_data,
    input  logic          i_rd,
    output logic          o_valid,
    output logic [W-1:0]  o_data
);
    import hds_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          pop;

    assign pop     = i_rd && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + NW'(i_wr) - NW'(pop);
        end
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// File: hdl/heat_diffusion_stencil_5pt_core.sv
// Top level of the five-point FTCS heat-equation stencil.
//
// i_in takes one grid word per cycle while ready, in raster order,
// boundary included. o_out gives one word per interior point: the
// updated value (signed, saturated), its row and column and frame_last
// on the grid's final interior point. i_cfg writes grid_size (index 0,
// resets the raster position) and diffusion_ratio (index 1); it is always
// ready. The user must write it only while the block is idle, which the
// block does not enforce. Results pass the stage-1, window and update
// registers and the queue. Throughput: one word per cycle while ready,
// set by the single read and write per cycle of each line buffer and a
// pipelined multiply. An 8-word output queue absorbs receiver stalls;
// i_in.ready drops only when every queue slot is claimed by results in
// flight or waiting, so input keeps flowing while a result waits.
// Reset: raster position cleared, grid_size 1024 (clamped to MAX_GRID),
// diffusion_ratio 13107; line buffer contents are not cleared.
module heat_diffusion_stencil_5pt_core #(
    parameter int MAX_GRID    = hds_pkg::MAX_GRID,
    parameter int VALUE_WIDTH = hds_pkg::VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hds_in_if.sink    i_in,
    hds_out_if.source o_out,
    hds_cfg_if.sink   i_cfg
);
    import hds_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int CW    = $clog2(MAX_GRID);
    localparam int TAG_W = 2 * CW + 1;
    localparam int QW    = VW + TAG_W;
    localparam int PNW   = $clog2(OUT_DEPTH + 1);
    localparam int RST_SIDE = (GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET;

    // configuration
    logic [CW-1:0]       r_nm1;
    logic [RATIO_W-1:0]  r_lambda;
    logic [GRID_W-1:0]   cfg_grid;
    int                  cfg_side;
    logic                cfg_wr;

    // raster position
    logic [CW-1:0] r_row, r_col;
    logic          accept, emit, last;

    // line buffers
    logic signed [VW-1:0] r_lb_upper  [MAX_GRID];
    logic signed [VW-1:0] r_lb_middle [MAX_GRID];
    logic signed [VW-1:0] r_rd_up, r_rd_mid;

    // stage 1 and window
    logic                 r_p1_valid, r_p1_emit;
    logic [TAG_W-1:0]     r_p1_tag;
    logic [CW-1:0]        r_p1_addr;
    logic signed [VW-1:0] r_p1_cur;
    logic                 r_p2_valid;
    logic [TAG_W-1:0]     r_p2_tag;
    logic signed [VW-1:0] r_w [3][3];

    // results
    logic                 upd_valid;
    logic [TAG_W-1:0]     upd_tag;
    logic signed [VW-1:0] upd_value;
    logic [QW-1:0]        q_data;
    logic                 q_valid;
    logic                 pop;
    logic [PNW-1:0]       r_pend;

    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_grid    = i_cfg.data[GRID_W-1:0];

    always_comb begin
        if (cfg_grid < GRID_W'(3)) begin
            cfg_side = 3;
        end else if (int'(cfg_grid) > MAX_GRID) begin
            cfg_side = MAX_GRID;
        end else begin
            cfg_side = int'(cfg_grid);
        end
    end

    assign i_in.ready = (r_pend < PNW'(OUT_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign emit       = (r_row >= CW'(2)) && (r_col >= CW'(2));
    assign last       = (r_row == r_nm1) && (r_col == r_nm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm1    <= CW'(RST_SIDE - 1);
            r_lambda <= RATIO_RESET;
            r_row    <= '0;
            r_col    <= '0;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                REG_GRID_SIZE: begin
                    r_nm1 <= CW'(cfg_side - 1);
                    r_row <= '0;
                    r_col <= '0;
                end
                REG_DIFF_RATIO: begin
                    r_lambda <= i_cfg.data[RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (r_col == r_nm1) begin
                r_col <= '0;
                r_row <= (r_row == r_nm1) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // middle buffer: read old row, store current word
    always_ff @(posedge i_clk) begin
        r_rd_mid <= r_lb_middle[r_col];
        if (accept) begin
            r_lb_middle[r_col] <= i_in.temperature;
        end
    end

    // upper buffer: takes the middle row word in the cycle after it is read
    always_ff @(posedge i_clk) begin
        r_rd_up <= r_lb_upper[r_col];
        if (r_p1_valid) begin
            r_lb_upper[r_p1_addr] <= r_rd_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p1_emit  <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= accept;
            r_p1_emit  <= accept && emit;
            r_p2_valid <= r_p1_valid && r_p1_emit;
        end
        r_p1_addr <= r_col;
        r_p1_cur  <= i_in.temperature;
        r_p1_tag  <= {r_row - 1'b1, r_col - 1'b1, last};
        if (r_p1_valid) begin
            r_p2_tag <= r_p1_tag;
            for (int k = 0; k < 3; k++) begin
                r_w[k][0] <= r_w[k][1];
                r_w[k][1] <= r_w[k][2];
            end
            r_w[0][2] <= r_rd_up;
            r_w[1][2] <= r_rd_mid;
            r_w[2][2] <= r_p1_cur;
        end
    end

    hds_update #(
        .VW    (VW),
        .TAG_W (TAG_W)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_p2_valid),
        .i_tag    (r_p2_tag),
        .i_up     (r_w[0][1]),
        .i_down   (r_w[2][1]),
        .i_left   (r_w[1][0]),
        .i_right  (r_w[1][2]),
        .i_center (r_w[1][1]),
        .i_lambda (r_lambda),
        .o_valid  (upd_valid),
        .o_tag    (upd_tag),
        .o_value  (upd_value)
    );

    hds_fifo #(
        .W     (QW),
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (upd_valid),
        .i_data  ({upd_value, upd_tag}),
        .i_rd    (o_out.ready),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign pop                   = q_valid && o_out.ready;
    assign o_out.valid           = q_valid;
    assign o_out.new_temperature = q_data[QW-1 -: VW];
    assign o_out.row_index       = q_data[TAG_W-1 -: CW];
    assign o_out.col_index       = q_data[CW -: CW];
    assign o_out.frame_last      = q_data[0];

    // results in flight or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PNW'(accept && emit) - PNW'(pop);
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PNW'(OUT_DEPTH))
        else $error("pending count exceeds queue depth");

    a_out_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_pend != '0)
        else $error("result shown without a pending claim");

    a_grid_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && i_cfg.index == REG_GRID_SIZE) |=> (r_row == '0 && r_col == '0))
        else $error("grid_size write did not restart raster");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_last) |-> (o_out.row_index == o_out.col_index))
        else $error("frame_last off the final diagonal point");
endmodule
